[src/esp_pkg.sv]
package esp_pkg;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_NOW   = 3'd0,
		REG_COEF_PREV  = 3'd1,
		REG_COEF_PREV2 = 3'd2,
		REG_SPEED_SCALE = 3'd3,
		REG_LPF_GAIN   = 3'd4,
		REG_INVERT     = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		DIR_COAST = 2'd0,
		DIR_FWD   = 2'd1,
		DIR_REV   = 2'd2
	} dir_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_RAW,
		ST_LPF_A,
		ST_LPF_B,
		ST_LPF_C,
		ST_FILT,
		ST_ERR,
		ST_P0,
		ST_P1,
		ST_P2,
		ST_P3,
		ST_UPD,
		ST_CLAMP,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		OP_RAW,
		OP_LPF_NEW,
		OP_LPF_OLD,
		OP_ERR0,
		OP_ERR1,
		OP_ERR2
	} op_sel_t;

	typedef struct packed {
		op_sel_t op_sel;
		logic    acc_en;
		logic    acc_clr;
		logic    win_clr;
		logic    filt_ld;
		logic    err_ld;
		logic    upd_ld;
		logic    clamp_ld;
		logic    out_ld;
	} ctl_t;

	localparam int MAC_W = 33;
	localparam int PROD_W = 2 * MAC_W;

	localparam logic [16:0] LPF_ONE = 17'h1_0000;
	localparam logic signed [31:0] LIMIT_Q = 32'sh00FF_0000;
	localparam logic signed [31:0] NEG_LIMIT_Q = -32'sh00FF_0000;
	localparam logic signed [15:0] WIN_MAX = 16'sh7FFF;
	localparam logic signed [15:0] WIN_MIN = -16'sh8000;
	localparam logic [7:0] DUTY_MAX = 8'd255;

	function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
		logic signed [31:0] r;
		if (v[PROD_W-1:31] == '0 || v[PROD_W-1:31] == '1) begin
			r = v[31:0];
		end else if (v[PROD_W-1]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7FFF_FFFF;
		end
		return r;
	endfunction

endpackage

[src/encoder_speed_pid_motor_drive.sv]
// Incremental PID speed controller for one wheel. An encoder item (cmd 0) updates the
// position and window counts and returns the held outputs. A tick with a zero setpoint
// coasts the wheel and clears the errors. A control tick steps one shared 33x33 multiplier
// with a registered product and a 66-bit accumulator through the raw speed, the two
// low-pass filter terms and the three PID terms. in_stall stays high while a tick runs. A
// finished result sits in an output register, so the next item is accepted while it waits.
// Configuration registers change at once: the user must write them between items for them
// to take effect on the next item; the block does not enforce this. cfg_ready is always high.
module encoder_speed_pid_motor_drive (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             cmd,
	input  logic                             enc_a,
	input  logic                             enc_b,
	input  logic signed [31:0]               target_speed,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [7:0]                       duty,
	output logic [1:0]                       drive_dir,
	output logic signed [31:0]               speed_now,
	output logic signed [31:0]               position,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [esp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                      cfg_data
);

	logic signed [31:0] coef_now_q;
	logic signed [31:0] coef_prev_q;
	logic signed [31:0] coef_prev2_q;
	logic [31:0]        scale_q;
	logic [16:0]        lpf_gain_q;
	logic               invert_q;

	logic signed [31:0] position_q;
	logic signed [15:0] win_q;
	logic signed [31:0] filt_q;
	logic signed [31:0] err_now_q;
	logic signed [31:0] err_last_q;
	logic signed [31:0] err_before_q;
	logic signed [31:0] out_last_q;
	logic [7:0]         duty_held_q;
	logic [1:0]         dir_held_q;
	logic signed [31:0] target_q;

	logic               out_valid_q;
	logic [7:0]         duty_out_q;
	logic [1:0]         dir_out_q;
	logic signed [31:0] speed_out_q;
	logic signed [31:0] position_out_q;

	esp_pkg::ctl_t      ctl;
	logic               busy;
	logic               in_acc;
	logic               tgt_zero;
	logic               out_free;
	logic               up;

	logic [16:0]        gain_eff;
	logic [16:0]        gain_rest;
	logic signed [31:0] raw_sat;
	logic signed [esp_pkg::MAC_W-1:0]  op_a;
	logic signed [esp_pkg::MAC_W-1:0]  op_b;
	logic signed [esp_pkg::PROD_W-1:0] prod;
	logic signed [esp_pkg::PROD_W-1:0] acc;
	logic signed [esp_pkg::PROD_W-1:0] acc_floor;
	logic signed [esp_pkg::PROD_W-1:0] err_diff;
	logic signed [esp_pkg::PROD_W-1:0] upd_sum;
	logic signed [31:0] neg_u;
	logic [7:0]         duty_d;
	logic [1:0]         dir_d;

	assign cfg_ready = 1'b1;
	assign in_stall  = busy;
	assign in_acc    = in_valid && !busy;
	assign tgt_zero  = (target_speed == '0);
	assign out_free  = !out_valid_q || !out_stall;
	assign up        = (enc_a == enc_b) ^ invert_q;

	esp_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.tgt_zero (tgt_zero),
		.out_free (out_free),
		.busy     (busy),
		.ctl      (ctl)
	);

	esp_mac u_mac (
		.clk  (clk),
		.ctl  (ctl),
		.op_a (op_a),
		.op_b (op_b),
		.prod (prod),
		.acc  (acc)
	);

	assign gain_eff  = lpf_gain_q[16] ? esp_pkg::LPF_ONE : lpf_gain_q;
	assign gain_rest = esp_pkg::LPF_ONE - gain_eff;
	assign raw_sat   = esp_pkg::sat32(prod);
	assign acc_floor = acc >>> 16;
	assign err_diff  = {{34{target_q[31]}}, target_q} - {{34{filt_q[31]}}, filt_q};
	assign upd_sum   = {{34{out_last_q[31]}}, out_last_q} + acc_floor;

	always_comb begin
		unique case (ctl.op_sel)
			esp_pkg::OP_RAW: begin
				op_a = {{17{win_q[15]}}, win_q};
				op_b = {1'b0, scale_q};
			end
			esp_pkg::OP_LPF_NEW: begin
				op_a = {raw_sat[31], raw_sat};
				op_b = {16'd0, gain_eff};
			end
			esp_pkg::OP_LPF_OLD: begin
				op_a = {filt_q[31], filt_q};
				op_b = {16'd0, gain_rest};
			end
			esp_pkg::OP_ERR0: begin
				op_a = {coef_now_q[31], coef_now_q};
				op_b = {err_now_q[31], err_now_q};
			end
			esp_pkg::OP_ERR1: begin
				op_a = {coef_prev_q[31], coef_prev_q};
				op_b = {err_last_q[31], err_last_q};
			end
			esp_pkg::OP_ERR2: begin
				op_a = {coef_prev2_q[31], coef_prev2_q};
				op_b = {err_before_q[31], err_before_q};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	always_comb begin
		neg_u = -out_last_q;
		priority if (out_last_q > esp_pkg::LIMIT_Q) begin
			duty_d = esp_pkg::DUTY_MAX;
			dir_d  = esp_pkg::DIR_FWD;
		end else if (out_last_q > 32'sd0) begin
			duty_d = out_last_q[23:16];
			dir_d  = esp_pkg::DIR_FWD;
		end else if (out_last_q < esp_pkg::NEG_LIMIT_Q) begin
			duty_d = esp_pkg::DUTY_MAX;
			dir_d  = esp_pkg::DIR_REV;
		end else if (out_last_q < 32'sd0) begin
			duty_d = neg_u[23:16];
			dir_d  = esp_pkg::DIR_REV;
		end else begin
			duty_d = '0;
			dir_d  = esp_pkg::DIR_COAST;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_now_q   <= '0;
			coef_prev_q  <= '0;
			coef_prev2_q <= '0;
			scale_q      <= '0;
			lpf_gain_q   <= esp_pkg::LPF_ONE;
			invert_q     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				esp_pkg::REG_COEF_NOW:    coef_now_q   <= cfg_data;
				esp_pkg::REG_COEF_PREV:   coef_prev_q  <= cfg_data;
				esp_pkg::REG_COEF_PREV2:  coef_prev2_q <= cfg_data;
				esp_pkg::REG_SPEED_SCALE: scale_q      <= cfg_data;
				esp_pkg::REG_LPF_GAIN:    lpf_gain_q   <= cfg_data[16:0];
				esp_pkg::REG_INVERT:      invert_q     <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q   <= '0;
			win_q        <= '0;
			filt_q       <= '0;
			err_last_q   <= '0;
			err_before_q <= '0;
			out_last_q   <= '0;
			duty_held_q  <= '0;
			dir_held_q   <= esp_pkg::DIR_COAST;
		end else begin
			if (in_acc && !cmd) begin
				if (up) begin
					position_q <= position_q + 32'sd1;
					if (win_q != esp_pkg::WIN_MAX) begin
						win_q <= win_q + 16'sd1;
					end
				end else begin
					position_q <= position_q - 32'sd1;
					if (win_q != esp_pkg::WIN_MIN) begin
						win_q <= win_q - 16'sd1;
					end
				end
			end
			if (in_acc && cmd && tgt_zero) begin
				win_q        <= '0;
				filt_q       <= '0;
				err_last_q   <= '0;
				err_before_q <= '0;
				duty_held_q  <= '0;
				dir_held_q   <= esp_pkg::DIR_COAST;
			end
			if (ctl.win_clr) begin
				win_q <= '0;
			end
			if (ctl.filt_ld) begin
				filt_q <= acc_floor[31:0];
			end
			if (ctl.upd_ld) begin
				out_last_q   <= esp_pkg::sat32(upd_sum);
				err_before_q <= err_last_q;
				err_last_q   <= err_now_q;
			end
			if (ctl.clamp_ld) begin
				duty_held_q <= duty_d;
				dir_held_q  <= dir_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			target_q <= target_speed;
		end
		if (ctl.err_ld) begin
			err_now_q <= esp_pkg::sat32(err_diff);
		end
		if (ctl.out_ld) begin
			duty_out_q     <= duty_held_q;
			dir_out_q      <= dir_held_q;
			speed_out_q    <= filt_q;
			position_out_q <= position_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign duty      = duty_out_q;
	assign drive_dir = dir_out_q;
	assign speed_now = speed_out_q;
	assign position  = position_out_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted on consecutive cycles");

	a_coast_no_duty: assert property (@(posedge clk) disable iff (!arst_n)
		dir_held_q == esp_pkg::DIR_COAST |-> duty_held_q == '0)
		else $error("coast with nonzero duty");

	a_duty_has_dir: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_ld |=> out_valid && (duty != '0) |-> (drive_dir != esp_pkg::DIR_COAST))
		else $error("duty driven without direction");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_ld |-> out_free)
		else $error("result loaded over a pending item");

endmodule

[src/esp_mac.sv]
module esp_mac (
	input  logic                                  clk,
	input  esp_pkg::ctl_t                         ctl,
	input  logic signed [esp_pkg::MAC_W-1:0]      op_a,
	input  logic signed [esp_pkg::MAC_W-1:0]      op_b,
	output logic signed [esp_pkg::PROD_W-1:0]     prod,
	output logic signed [esp_pkg::PROD_W-1:0]     acc
);

	logic signed [esp_pkg::PROD_W-1:0] prod_s1;
	logic signed [esp_pkg::PROD_W-1:0] acc_q;

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
		if (ctl.acc_en) begin
			acc_q <= (ctl.acc_clr ? '0 : acc_q) + prod_s1;
		end
	end

	assign prod = prod_s1;
	assign acc  = acc_q;

endmodule

[src/esp_seq.sv]
module esp_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          cmd,
	input  logic          tgt_zero,
	input  logic          out_free,
	output logic          busy,
	output esp_pkg::ctl_t ctl
);

	esp_pkg::state_t state_q;
	esp_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= esp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl = '0;
		ctl.op_sel = esp_pkg::OP_RAW;
		busy = (state_q != esp_pkg::ST_IDLE);
		unique case (state_q)
			esp_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = (cmd && !tgt_zero) ? esp_pkg::ST_MUL_RAW : esp_pkg::ST_DONE;
				end
			end
			esp_pkg::ST_MUL_RAW: begin
				ctl.op_sel = esp_pkg::OP_RAW;
				state_d = esp_pkg::ST_LPF_A;
			end
			esp_pkg::ST_LPF_A: begin
				ctl.op_sel = esp_pkg::OP_LPF_NEW;
				ctl.win_clr = 1'b1;
				state_d = esp_pkg::ST_LPF_B;
			end
			esp_pkg::ST_LPF_B: begin
				ctl.op_sel = esp_pkg::OP_LPF_OLD;
				ctl.acc_en = 1'b1;
				ctl.acc_clr = 1'b1;
				state_d = esp_pkg::ST_LPF_C;
			end
			esp_pkg::ST_LPF_C: begin
				ctl.acc_en = 1'b1;
				state_d = esp_pkg::ST_FILT;
			end
			esp_pkg::ST_FILT: begin
				ctl.filt_ld = 1'b1;
				state_d = esp_pkg::ST_ERR;
			end
			esp_pkg::ST_ERR: begin
				ctl.err_ld = 1'b1;
				state_d = esp_pkg::ST_P0;
			end
			esp_pkg::ST_P0: begin
				ctl.op_sel = esp_pkg::OP_ERR0;
				state_d = esp_pkg::ST_P1;
			end
			esp_pkg::ST_P1: begin
				ctl.op_sel = esp_pkg::OP_ERR1;
				ctl.acc_en = 1'b1;
				ctl.acc_clr = 1'b1;
				state_d = esp_pkg::ST_P2;
			end
			esp_pkg::ST_P2: begin
				ctl.op_sel = esp_pkg::OP_ERR2;
				ctl.acc_en = 1'b1;
				state_d = esp_pkg::ST_P3;
			end
			esp_pkg::ST_P3: begin
				ctl.acc_en = 1'b1;
				state_d = esp_pkg::ST_UPD;
			end
			esp_pkg::ST_UPD: begin
				ctl.upd_ld = 1'b1;
				state_d = esp_pkg::ST_CLAMP;
			end
			esp_pkg::ST_CLAMP: begin
				ctl.clamp_ld = 1'b1;
				state_d = esp_pkg::ST_DONE;
			end
			esp_pkg::ST_DONE: begin
				if (out_free) begin
					ctl.out_ld = 1'b1;
					state_d = esp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = esp_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[dv/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 5000;
	localparam int SQUEEZE_CYCLES = 500;
	localparam int PHASE_ITEMS = 200;
	localparam int WINDOW_RUN = 40;

	typedef struct {
		logic [7:0]         duty;
		logic [1:0]         dir;
		logic signed [31:0] speed;
		logic signed [31:0] pos;
	} drive_result_t;

	class drive_scoreboard;
		logic signed [31:0] k_now, k_prev, k_prev2;
		logic [31:0]        scale;
		logic [16:0]        gain;
		logic               invert;
		logic [31:0]        pos;
		logic signed [15:0] win;
		logic signed [31:0] filt, err1, err2, u_last;
		logic [7:0]         duty_q;
		logic [1:0]         dir_q;
		drive_result_t      pending[$];
		int                 mismatches;

		function new();
			k_now = '0; k_prev = '0; k_prev2 = '0;
			scale = '0; gain = esp_pkg::LPF_ONE; invert = 1'b0;
			pos = '0; win = '0;
			filt = '0; err1 = '0; err2 = '0; u_last = '0;
			duty_q = '0; dir_q = esp_pkg::DIR_COAST;
			mismatches = 0;
		endfunction

		function logic signed [31:0] clip32(longint v);
			logic signed [31:0] r;
			if (v > 64'sd2147483647) r = 32'sh7FFF_FFFF;
			else if (v < -64'sd2147483648) r = 32'sh8000_0000;
			else r = v[31:0];
			return r;
		endfunction

		function void write_reg(esp_pkg::cfg_reg_t idx, logic [31:0] data);
			case (idx)
			esp_pkg::REG_COEF_NOW: k_now = data;
			esp_pkg::REG_COEF_PREV: k_prev = data;
			esp_pkg::REG_COEF_PREV2: k_prev2 = data;
			esp_pkg::REG_SPEED_SCALE: scale = data;
			esp_pkg::REG_LPF_GAIN: gain = data[16:0];
			esp_pkg::REG_INVERT: invert = data[0];
			default: ;
			endcase
		endfunction

		function void take_item(logic c, logic ea, logic eb, logic signed [31:0] target);
			logic          up;
			longint        raw, g, e, p0, p1, p2, hi, lo, u, mix;
			drive_result_t r;
			if (!c) begin
				up = (ea == eb) ^ invert;
				if (up) begin
					pos = pos + 32'd1;
					if (win != esp_pkg::WIN_MAX) win = win + 16'sd1;
				end else begin
					pos = pos - 32'd1;
					if (win != esp_pkg::WIN_MIN) win = win - 16'sd1;
				end
			end else if (target == 32'sd0) begin
				win = '0;
				filt = '0;
				err1 = '0;
				err2 = '0;
				duty_q = '0;
				dir_q = esp_pkg::DIR_COAST;
			end else begin
				raw = clip32(longint'(win) * longint'(scale));
				g = (gain > esp_pkg::LPF_ONE) ? 64'sd65536 : longint'(gain);
				mix = (raw * g + longint'(filt) * (64'sd65536 - g)) >>> 16;
				filt = mix[31:0];
				win = '0;
				e = clip32(longint'(target) - longint'(filt));
				p0 = longint'(k_now) * e;
				p1 = longint'(k_prev) * longint'(err1);
				p2 = longint'(k_prev2) * longint'(err2);
				hi = (p0 >>> 16) + (p1 >>> 16) + (p2 >>> 16);
				lo = longint'(p0[15:0]) + longint'(p1[15:0]) + longint'(p2[15:0]);
				u_last = clip32(longint'(u_last) + hi + (lo >>> 16));
				err2 = err1;
				err1 = e[31:0];
				u = longint'(u_last);
				if (u > longint'(esp_pkg::LIMIT_Q)) u = longint'(esp_pkg::LIMIT_Q);
				if (u < longint'(esp_pkg::NEG_LIMIT_Q)) u = longint'(esp_pkg::NEG_LIMIT_Q);
				if (u > 0) begin
					dir_q = esp_pkg::DIR_FWD;
					duty_q = u[23:16];
				end else if (u < 0) begin
					dir_q = esp_pkg::DIR_REV;
					u = -u;
					duty_q = u[23:16];
				end else begin
					dir_q = esp_pkg::DIR_COAST;
					duty_q = '0;
				end
			end
			r.duty = duty_q;
			r.dir = dir_q;
			r.speed = filt;
			r.pos = pos;
			pending.push_back(r);
		endfunction

		function void check_result(logic [7:0] d, logic [1:0] dr, logic signed [31:0] sp,
				logic signed [31:0] ps);
			drive_result_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("tb: unexpected item duty=%0d dir=%0d speed=%0d pos=%0d",
						d, dr, sp, ps);
				return;
			end
			want = pending.pop_front();
			if (d !== want.duty || dr !== want.dir || sp !== want.speed || ps !== want.pos) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"tb: mismatch exp duty=%0d dir=%0d speed=%0d pos=%0d",
						" got duty=%0d dir=%0d speed=%0d pos=%0d"},
						want.duty, want.dir, want.speed, want.pos, d, dr, sp, ps);
			end
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic                          cmd = 1'b0;
	logic                          enc_a = 1'b0;
	logic                          enc_b = 1'b0;
	logic signed [31:0]            target_speed = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [7:0]                    duty;
	logic [1:0]                    drive_dir;
	logic signed [31:0]            speed_now;
	logic signed [31:0]            position;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [esp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]                   cfg_data = '0;

	bit squeeze_req = 1'b0;
	bit squeeze_done = 1'b0;

	drive_scoreboard sb;

	encoder_speed_pid_motor_drive i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.enc_a        (enc_a),
		.enc_b        (enc_b),
		.target_speed (target_speed),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.duty         (duty),
		.drive_dir    (drive_dir),
		.speed_now    (speed_now),
		.position     (position),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 75) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic int pick_run();
		if ($urandom_range(0, 9) == 0) return $urandom_range(100, 300);
		return $urandom_range(1, 20);
	endfunction

	function automatic logic [31:0] pick_coef();
		return $urandom_range(0, 32'h0001_0000) - 32'h0000_8000;
	endfunction

	function automatic logic [31:0] pick_target();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) return 32'h0;
		if (r < 18) return $urandom;
		if (r < 23) begin
			case ($urandom_range(0, 3))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0001;
			default: return 32'hFFFF_FFFF;
			endcase
		end
		return $urandom_range(0, 800 * 65536) - 400 * 65536;
	endfunction

	task automatic send_item(input logic c, input logic ea, input logic eb,
			input logic [31:0] t, input int gap);
		in_valid <= 1'b1;
		cmd <= c;
		enc_a <= ea;
		enc_b <= eb;
		target_speed <= t;
		do @(posedge clk); while (in_stall);
		sb.take_item(c, ea, eb, t);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_cfg(input esp_pkg::cfg_reg_t idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	task automatic program_regs(input logic [31:0] v0, input logic [31:0] v1,
			input logic [31:0] v2, input logic [31:0] v3, input logic [31:0] v4,
			input logic [31:0] v5);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		write_cfg(esp_pkg::REG_COEF_NOW, v0);
		write_cfg(esp_pkg::REG_COEF_PREV, v1);
		write_cfg(esp_pkg::REG_COEF_PREV2, v2);
		write_cfg(esp_pkg::REG_SPEED_SCALE, v3);
		write_cfg(esp_pkg::REG_LPF_GAIN, v4);
		write_cfg(esp_pkg::REG_INVERT, v5);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_phase(input int n);
		int   left;
		int   k;
		logic up;
		logic ea;
		logic eb;
		left = n;
		while (left > 0) begin
			if ($urandom_range(0, 9) == 0) begin
				send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), $urandom, pick_gap());
				left--;
			end else begin
				k = $urandom_range(0, 30);
				up = 1'($urandom_range(0, 1));
				repeat (k) begin
					ea = 1'($urandom_range(0, 1));
					eb = up ? ea : ~ea;
					if ($urandom_range(0, 6) == 0) eb = 1'($urandom_range(0, 1));
					send_item(1'b0, ea, eb, $urandom, pick_gap());
				end
				send_item(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					pick_target(), pick_gap());
				left -= k + 1;
			end
		end
	endtask

	initial begin : result_sink
		int run_left;
		int stall_left;
		run_left = 0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				sb.check_result(duty, drive_dir, speed_now, position);
			if (squeeze_req && !squeeze_done) begin
				squeeze_done = 1'b1;
				run_left = 0;
				stall_left = SQUEEZE_CYCLES;
			end else if (run_left == 0 && stall_left == 0) begin
				run_left = pick_run();
				stall_left = pick_gap();
			end
			if (run_left > 0) begin
				out_stall <= 1'b0;
				run_left--;
			end else begin
				out_stall <= 1'b1;
				stall_left--;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin : stimulus
		int ph;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		program_regs(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0);
		send_item(1'b0, 1'b0, 1'b0, 32'h0, pick_gap());
		send_item(1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF, pick_gap());
		send_item(1'b0, 1'b0, 1'b1, 32'h0, pick_gap());
		send_item(1'b0, 1'b1, 1'b0, 32'h0, pick_gap());
		send_item(1'b1, 1'b0, 1'b0, 32'd300, pick_gap());
		send_item(1'b1, 1'b1, 1'b1, -32'sd600, pick_gap());
		send_item(1'b1, 1'b0, 1'b0, 32'd300, pick_gap());
		send_item(1'b1, 1'b0, 1'b0, 32'h7FFF_FFFF, pick_gap());
		send_item(1'b1, 1'b0, 1'b0, 32'h7FFF_FFFF, pick_gap());
		send_item(1'b1, 1'b0, 1'b0, 32'h8000_0000, pick_gap());
		send_item(1'b1, 1'b0, 1'b0, 32'h0, pick_gap());

		program_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
			32'h0001_FFFF, 32'h1);
		send_item(1'b0, 1'b1, 1'b1, 32'h0, pick_gap());
		send_item(1'b0, 1'b0, 1'b0, 32'h0, pick_gap());
		send_item(1'b1, 1'b0, 1'b0, 32'h0064_0000, pick_gap());
		send_item(1'b0, 1'b0, 1'b1, 32'h0, pick_gap());
		send_item(1'b0, 1'b1, 1'b0, 32'h0, pick_gap());
		send_item(1'b1, 1'b0, 1'b0, 32'h8000_0000, pick_gap());
		send_item(1'b1, 1'b0, 1'b0, 32'h7FFF_FFFF, pick_gap());
		send_item(1'b1, 1'b0, 1'b0, 32'h0000_0001, pick_gap());
		send_item(1'b1, 1'b0, 1'b0, 32'h0, pick_gap());

		program_regs(32'h0000_4000, 32'hFFFF_E000, 32'h0000_1000, 32'h0000_0100,
			32'h0000_C000, 32'h0);
		repeat (WINDOW_RUN) send_item(1'b0, 1'b1, 1'b1, 32'h0, 0);
		send_item(1'b1, 1'b0, 1'b0, 32'h0100_0000, 0);
		repeat (WINDOW_RUN) send_item(1'b0, 1'b1, 1'b0, 32'h0, 0);
		send_item(1'b1, 1'b0, 1'b0, 32'hFF00_0000, 0);

		for (ph = 0; ph < 6; ph++) begin
			case (ph)
			0: program_regs(pick_coef(), pick_coef(), pick_coef(),
				$urandom_range(0, 32'h0008_0000), $urandom_range(0, 65536), 32'h0);
			1: program_regs(pick_coef(), pick_coef(), pick_coef(),
				$urandom_range(0, 32'h0008_0000), 32'h0, 32'h1);
			2: program_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			3: program_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
				32'h0001_0000, 32'h0);
			4: program_regs(32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_FFFF, 32'h1);
			default: program_regs(pick_coef(), pick_coef(), pick_coef(),
				$urandom_range(0, 32'h0008_0000), $urandom_range(1, 65536),
				$urandom_range(0, 1));
			endcase
			if (ph == 2) squeeze_req = 1'b1;
			random_phase(PHASE_ITEMS);
		end

		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
